// ----- design/rsm_pkg.sv -----
// ---------------------------------------------------------------------------
// rsm_pkg
// Types and constants shared by the row softmax controller and datapath.
// ---------------------------------------------------------------------------
package rsm_pkg;

   localparam logic [16:0] LOG2E_Q16     = 17'd94548;
   localparam logic [15:0] EXP_FLOOR_Q88 = 16'd22528;
   localparam logic [24:0] C0 = 25'd16777216;
   localparam logic [24:0] C1 = 25'd11629080;
   localparam logic [24:0] C2 = 25'd4030332;
   localparam logic [24:0] C3 = 25'd931204;
   localparam logic [24:0] C4 = 25'd161365;
   localparam logic [24:0] C5 = 25'd22370;
   localparam logic [24:0] C6 = 25'd2584;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_EXP_RD,
      ST_EXP_W,
      ST_EXP_HORN,
      ST_EXP_ACC,
      ST_DIV,
      ST_OUT_RD,
      ST_OUT_EXP,
      ST_OUT_MUL,
      ST_OUT_EMIT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // store req_value, update max
      logic clear_row;  // reset max and sum
      logic mem_rd;     // read row entry at index
      logic w_calc;     // compute w, k, f from stored entry
      logic horn_init;  // start polynomial
      logic horn_step;  // one horner step
      logic acc;        // finish exp, write exp store, accumulate
      logic div_init;
      logic div_step;
      logic exp_rd;     // read exp store at index
      logic mul;        // e * inv
   } ctrl_type;

   // status back to controller
   typedef struct packed {
      logic div_done;
   } stat_type;

   // coefficient used at horner step i (0 -> c5 ... 5 -> c0)
   function automatic logic [24:0] horner_coef(input logic [2:0] i);
      logic [24:0] c;
      unique case (i)
         3'd0:    c = C5;
         3'd1:    c = C4;
         3'd2:    c = C3;
         3'd3:    c = C2;
         3'd4:    c = C1;
         default: c = C0;
      endcase
      return c;
   endfunction

endpackage

// ----- design/rsm_datapath.sv -----
// ---------------------------------------------------------------------------
// rsm_datapath
// Row store, exp2 unit, sum, restoring divider and output scaling.
// ---------------------------------------------------------------------------
module rsm_datapath #(
   parameter int IDX_W = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rsm_pkg::ctrl_type    ctrl,
   input  logic [IDX_W-1:0]     idx,
   input  logic [2:0]           horn_idx,
   input  logic signed [15:0]   in_value,
   output rsm_pkg::stat_type    stat,
   output logic [15:0]          prob
);

   logic [15:0] row_mem [2**IDX_W];
   logic [16:0] exp_mem [2**IDX_W];

   logic signed [15:0] max_ff, max_in;
   logic [22:0]        sum_ff, sum_in;
   logic [15:0]        rd_ff;
   logic [16:0]        erd_ff;
   logic [16:0]        f_ff;
   logic [7:0]         s_ff;
   logic               zero_ff;
   logic [24:0]        p_ff;
   logic [40:0]        rem_ff;
   logic [40:0]        quo_ff;
   logic [5:0]         dcnt_ff;
   logic [41:0]        prod_ff;

   logic signed [16:0] diff;
   logic [16:0]        a;
   logic [33:0]        wprod;
   logic [25:0]        w;
   logic [9:0]         k;
   logic [15:0]        r;
   logic [41:0]        hmul;
   logic [16:0]        e_val;
   logic [40:0]        rem_sh;
   logic [40:0]        dvs;
   logic [42:0]        q_rnd;

   always_comb begin
      max_in = max_ff;
      sum_in = sum_ff;
      if (ctrl.clear_row) begin
         max_in = -16'sd32768;
         sum_in = '0;
      end else begin
         if (ctrl.load && (in_value > max_ff)) max_in = in_value;
         if (ctrl.acc) sum_in = sum_ff + 23'(e_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= -16'sd32768;
         sum_ff <= '0;
      end else begin
         max_ff <= max_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) row_mem[idx] <= in_value;
      if (ctrl.mem_rd) rd_ff <= row_mem[idx];
      if (ctrl.acc) exp_mem[idx] <= e_val;
      if (ctrl.exp_rd) erd_ff <= exp_mem[idx];
   end

   // exponent split: w = round(a*log2e/256), z = -m + f
   assign diff  = 17'(max_ff) - 17'(signed'(rd_ff));
   assign a     = 17'(diff);
   assign wprod = 34'(a) * 34'(rsm_pkg::LOG2E_Q16) + 34'd128;
   assign w     = wprod[33:8];
   assign k     = w[25:16];
   assign r     = w[15:0];

   always_ff @(posedge clock) begin
      if (ctrl.w_calc) begin
         zero_ff <= (a > 17'(rsm_pkg::EXP_FLOOR_Q88));
         if (r == 16'd0) begin
            f_ff <= '0;
            s_ff <= 8'd8 + 8'(k);
         end else begin
            f_ff <= 17'd65536 - 17'(r);
            s_ff <= 8'd9 + 8'(k);
         end
      end
   end

   assign hmul = 42'(p_ff) * 42'(f_ff);

   always_ff @(posedge clock) begin
      if (ctrl.horn_init) p_ff <= rsm_pkg::C6;
      else if (ctrl.horn_step) p_ff <= 25'(hmul >> 16) + rsm_pkg::horner_coef(horn_idx);
   end

   always_comb begin
      if (zero_ff || s_ff >= 8'd40) e_val = '0;
      else e_val = 17'(p_ff >> s_ff[5:0]);
   end

   // restoring divider for floor(2^40 / sum), one quotient bit a cycle
   assign dvs    = 41'(sum_ff);
   assign rem_sh = {rem_ff[39:0], (dcnt_ff == 6'd41)};
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (ctrl.div_init) begin
         dcnt_ff <= 6'd41;
      end else if (ctrl.div_step && dcnt_ff != 6'd0) begin
         dcnt_ff <= dcnt_ff - 6'd1;
      end
   end
   always_ff @(posedge clock) begin
      if (ctrl.div_init) begin
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (ctrl.div_step && dcnt_ff != 6'd0) begin
         if (sum_ff != '0 && rem_sh >= dvs) begin
            rem_ff <= rem_sh - dvs;
            quo_ff <= {quo_ff[39:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[39:0], 1'b0};
         end
      end
   end
   // dividend 2^40: bit 40 enters at the first step, all other bits zero
   assign stat.div_done = (dcnt_ff == 6'd0);

   // the row max alone adds 65536 to the sum, so inv fits in 25 bits
   always_ff @(posedge clock) begin
      if (ctrl.mul) prod_ff <= 42'(erd_ff) * 42'(quo_ff[24:0]);
   end

   assign q_rnd = 43'(prod_ff) + 43'd8388608;
   assign prob  = (q_rnd[42:24] > 19'd65535) ? 16'hFFFF : q_rnd[39:24];

endmodule

// ----- design/rsm_ctrl.sv -----
// ---------------------------------------------------------------------------
// rsm_ctrl
// Sequencer for load, exp pass, reciprocal and emit pass.
// ---------------------------------------------------------------------------
module rsm_ctrl #(
   parameter int MAX_COLS = 64,
   parameter int IDX_W    = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               in_last,
   input  rsm_pkg::stat_type  stat,
   output logic               busy,
   output rsm_pkg::ctrl_type  ctrl,
   output logic [IDX_W-1:0]   idx,
   output logic [2:0]         horn_idx,
   output logic               rsp_valid,
   output logic               rsp_last_res
);

   rsm_pkg::state_type state_ff, state_in;
   logic [IDX_W:0] cnt_ff, cnt_in;   // elements in row
   logic [IDX_W:0] pos_ff, pos_in;   // pass position
   logic [2:0]     h_ff, h_in;
   logic           accept;
   logic           row_end;

   assign accept  = start && (state_ff == rsm_pkg::ST_LOAD);
   assign row_end = in_last || (cnt_ff + 1'b1 >= (IDX_W+1)'(MAX_COLS));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      h_in     = h_ff;
      unique case (state_ff)
         rsm_pkg::ST_LOAD: begin
            if (accept) begin
               cnt_in = cnt_ff + 1'b1;
               if (row_end) begin
                  state_in = rsm_pkg::ST_EXP_RD;
                  pos_in   = '0;
               end
            end
         end
         rsm_pkg::ST_EXP_RD:   state_in = rsm_pkg::ST_EXP_W;
         rsm_pkg::ST_EXP_W: begin
            state_in = rsm_pkg::ST_EXP_HORN;
            h_in     = '0;
         end
         rsm_pkg::ST_EXP_HORN: begin
            h_in = h_ff + 3'd1;
            if (h_ff == 3'd6) state_in = rsm_pkg::ST_EXP_ACC;
         end
         rsm_pkg::ST_EXP_ACC: begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff + 1'b1 == cnt_ff) state_in = rsm_pkg::ST_DIV;
            else state_in = rsm_pkg::ST_EXP_RD;
         end
         rsm_pkg::ST_DIV: begin
            pos_in = '0;
            if (h_ff == 3'd0 && stat.div_done) state_in = rsm_pkg::ST_OUT_RD;
            h_in = '0;
         end
         rsm_pkg::ST_OUT_RD:  state_in = rsm_pkg::ST_OUT_EXP;
         rsm_pkg::ST_OUT_EXP: state_in = rsm_pkg::ST_OUT_MUL;
         rsm_pkg::ST_OUT_MUL: state_in = rsm_pkg::ST_OUT_EMIT;
         rsm_pkg::ST_OUT_EMIT: begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff + 1'b1 == cnt_ff) begin
               state_in = rsm_pkg::ST_LOAD;
               cnt_in   = '0;
            end else begin
               state_in = rsm_pkg::ST_OUT_RD;
            end
         end
         default: state_in = rsm_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsm_pkg::ST_LOAD;
         cnt_ff   <= '0;
         pos_ff   <= '0;
         h_ff     <= 3'd7;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         // h_ff==7 on entry to ST_DIV marks the divider start cycle
         h_ff     <= (state_ff == rsm_pkg::ST_EXP_ACC) ? 3'd7 : h_in;
      end
   end

   always_comb begin
      ctrl         = '0;
      busy         = 1'b1;
      idx          = pos_ff[IDX_W-1:0];
      horn_idx     = 3'd0;
      rsp_valid    = 1'b0;
      rsp_last_res = 1'b0;
      unique case (state_ff)
         rsm_pkg::ST_LOAD: begin
            busy      = 1'b0;
            idx       = cnt_ff[IDX_W-1:0];
            ctrl.load = accept;
         end
         rsm_pkg::ST_EXP_RD:   ctrl.mem_rd = 1'b1;
         rsm_pkg::ST_EXP_W: begin
            ctrl.w_calc    = 1'b1;
            ctrl.horn_init = 1'b1;
         end
         rsm_pkg::ST_EXP_HORN: begin
            horn_idx       = h_ff;
            ctrl.horn_step = (h_ff != 3'd6);
         end
         rsm_pkg::ST_EXP_ACC:  ctrl.acc = 1'b1;
         rsm_pkg::ST_DIV: begin
            ctrl.div_init = (h_ff == 3'd7);
            ctrl.div_step = (h_ff != 3'd7);
         end
         rsm_pkg::ST_OUT_RD:   ctrl.exp_rd = 1'b1;
         rsm_pkg::ST_OUT_EXP:  ctrl.mul = 1'b0;
         rsm_pkg::ST_OUT_MUL:  ctrl.mul = 1'b1;
         rsm_pkg::ST_OUT_EMIT: begin
            rsp_valid      = 1'b1;
            rsp_last_res   = (pos_ff + 1'b1 == cnt_ff);
            ctrl.clear_row = (pos_ff + 1'b1 == cnt_ff);
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

// ----- design/row_softmax_unit_top.sv -----
// row_softmax_unit_top: one input item per cycle while loading a row.
// after the last element the exp pass reads, splits, runs Horner steps
// (one Horner step a cycle) and accumulates each element, then the
// bit-serial reciprocal runs, then one result per element; busy stays
// high until the last result. results are never stalled by the receiver.
// synchronous active-high reset clears the sequencer, max and sum.
// ---------------------------------------------------------------------------
// row_softmax_unit_top
// Fixed-point numerically stable softmax over rows of up to MAX_COLS items.
// ---------------------------------------------------------------------------
module row_softmax_unit_top #(
   parameter int MAX_COLS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   output logic [15:0]        rsp_prob,
   output logic               rsp_last_res
);

   localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   rsm_pkg::ctrl_type ctrl;
   rsm_pkg::stat_type stat;
   logic [IDX_W-1:0]  idx;
   logic [2:0]        horn_idx;

   rsm_ctrl #(.MAX_COLS(MAX_COLS), .IDX_W(IDX_W)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .in_last(req_last),
      .stat(stat), .busy(busy), .ctrl(ctrl), .idx(idx), .horn_idx(horn_idx),
      .rsp_valid(rsp_valid), .rsp_last_res(rsp_last_res)
   );

   rsm_datapath #(.IDX_W(IDX_W)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .idx(idx),
      .horn_idx(horn_idx), .in_value(req_value), .stat(stat), .prob(rsp_prob)
   );

endmodule
